FILE: sv/grid_ray_traversal_macros.svh
`ifndef GRID_RAY_TRAVERSAL_MACROS_SVH
`define GRID_RAY_TRAVERSAL_MACROS_SVH

// same-cycle implication
`define GRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grt assertion failed");

// next-cycle implication
`define GRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grt assertion failed");

`endif

FILE: sv/grt_pkg.sv
package grt_pkg;

  localparam int unsigned POS_W     = 22;
  localparam int unsigned DIR_W     = 16;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned SQ_W      = 32;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned DIM_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } opcode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 2'd2;

  localparam logic [DIM_W-1:0]  MAP_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0]  MAP_HEIGHT_RST = 7'd64;
  localparam logic [DIST_W-1:0] MAX_DIST_RST   = 24'd4194304;
  localparam logic [DIST_W-1:0] DIST_SAT       = 24'hFFFFFF;

endpackage

FILE: sv/grt_ram.sv
module grt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/grt_sqrt.sv
module grt_sqrt #(
  parameter int unsigned IN_W = 32,
  localparam int unsigned OUT_W = IN_W / 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IN_W-1:0]  radicand_i,
  output logic             done_o,
  output logic [OUT_W-1:0] root_o
);

  localparam int unsigned CNT_W = $clog2(OUT_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IN_W-1:0]  rad_q;
  logic [OUT_W:0]   rem_q;
  logic [OUT_W-1:0] root_q;

  logic [OUT_W+2:0] rem_sh, trial;
  logic             fits;

  assign rem_sh = {rem_q, rad_q[IN_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(OUT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? (OUT_W+1)'(rem_sh - trial) : (OUT_W+1)'(rem_sh);
      root_q <= {root_q[OUT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: sv/grt_div.sv
module grt_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;

  logic [DEN_W:0] rem_sh;
  logic           fits;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      num_q <= {num_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

FILE: sv/grid_ray_traversal.sv
// a cast first sets up: the squares, a bit-serial square root, a divide per nonzero direction
// component and the initial lengths; then it walks cell by cell and finishes; the shared bit-serial divider and
// the square root set the setup, the one-read-per-cell RAM sets the walk
// one cast is in flight at a time
// reset clears control and loads map_width 64, map_height 64, max_distance 0x400000
// the wall RAM is not cleared: a cast must only read cells written before
module grid_ray_traversal import grt_pkg::*; #(
  parameter int unsigned MAP_DIM   = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [DIST_W-1:0]       cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic [IDX_W-1:0]        cell_index_i,
  input  logic                    cell_wall_i,
  input  logic [POS_W-1:0]        start_x_i,
  input  logic [POS_W-1:0]        start_y_i,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DIST_W-1:0]       distance_o,
  output logic                    hit_o,
  output logic                    out_of_map_o,
  output logic [CELL_W-1:0]       end_cell_x_o,
  output logic [CELL_W-1:0]       end_cell_y_o
);

  localparam int unsigned CELLS   = MAP_DIM * MAP_DIM;
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned WADDR_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int unsigned CW      = $clog2(MAP_DIM);
  localparam int unsigned INT_W   = (POS_W > FRAC_BITS) ? (POS_W - FRAC_BITS) : 1;
  localparam int unsigned XW      = ((INT_W > CW) ? INT_W : CW) + 2;
  localparam int unsigned CMP_W   = ((XW > DIM_W) ? XW : DIM_W) + 1;
  localparam int unsigned PRD_W   = CW + DIM_W;
  localparam int unsigned SUM_W   = ((PRD_W > ADDR_W) ? PRD_W : ADDR_W) + 1;
  localparam int unsigned QW      = NORM_W + FRAC_BITS;
  localparam int unsigned LW      = QW + 10;
  localparam int unsigned HALF    = (QW + 1) / 2;
  localparam int unsigned MA_W    = (FRAC_BITS + 1 > MAG_W) ? (FRAC_BITS + 1) : MAG_W;
  localparam int unsigned MB_W    = (HALF > MAG_W) ? HALF : MAG_W;
  localparam int unsigned MP_W    = MA_W + MB_W;
  localparam int unsigned FULL_W  = FRAC_BITS + QW + 2;

  localparam logic signed [XW-1:0] STEP_FWD  = XW'(1);
  localparam logic signed [XW-1:0] STEP_BACK = XW'(-1);
  localparam logic [FRAC_BITS:0]   ONE       = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_SQX    = 18'h00002,
    S_SQY    = 18'h00004,
    S_ROOTGO = 18'h00008,
    S_ROOT   = 18'h00010,
    S_DIVXGO = 18'h00020,
    S_DIVX   = 18'h00040,
    S_DIVYGO = 18'h00080,
    S_DIVY   = 18'h00100,
    S_LXL    = 18'h00200,
    S_LXH    = 18'h00400,
    S_LYL    = 18'h00800,
    S_LYH    = 18'h01000,
    S_LEND   = 18'h02000,
    S_START  = 18'h04000,
    S_STEP   = 18'h08000,
    S_CHECK  = 18'h10000,
    S_OUT    = 18'h20000
  } state_e;

  state_e state_q, state_d;

  logic [DIM_W-1:0]  map_width_q, map_height_q;
  logic [DIST_W-1:0] max_dist_q;

  logic                 xneg_q, yneg_q;
  logic [MAG_W-1:0]     magx_q, magy_q;
  logic [FRAC_BITS:0]   fracx_q, fracy_q;
  logic signed [XW-1:0] cx_q, cy_q;
  logic [MP_W-1:0]      mul_q, acc_q;
  logic [NORM_W-1:0]    norm_q;
  logic [QW-1:0]        dlx_q, dly_q;
  logic [LW-1:0]        lenx_q, leny_q, dist_q;
  logic                 hit_q, oom_q;

  logic              out_valid_q;
  logic [DIST_W-1:0] res_dist_q;
  logic              res_hit_q, res_oom_q;
  logic [CELL_W-1:0] res_cx_q, res_cy_q;

  logic in_acc, xon, yon;
  assign in_acc     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign xon        = |magx_q;
  assign yon        = |magy_q;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
      max_dist_q   <= MAX_DIST_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_MAX_DIST:   max_dist_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accept-time decode of direction
  logic [MAG_W-1:0]     rawx, rawy, magx_d, magy_d;
  logic [FRAC_BITS-1:0] fx, fy;
  assign rawx   = dir_x_i;
  assign rawy   = dir_y_i;
  assign magx_d = rawx[MAG_W-1] ? ((~rawx) + MAG_W'(1)) : rawx;
  assign magy_d = rawy[MAG_W-1] ? ((~rawy) + MAG_W'(1)) : rawy;
  assign fx     = FRAC_BITS'(start_x_i);
  assign fy     = FRAC_BITS'(start_y_i);

  // shared multiplier
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQX: begin
        mul_a = MA_W'(magx_q);
        mul_b = MB_W'(magx_q);
      end
      S_SQY: begin
        mul_a = MA_W'(magy_q);
        mul_b = MB_W'(magy_q);
      end
      S_LXL: begin
        mul_a = MA_W'(fracx_q);
        mul_b = MB_W'(dlx_q[HALF-1:0]);
      end
      S_LXH: begin
        mul_a = MA_W'(fracx_q);
        mul_b = MB_W'(dlx_q[QW-1:HALF]);
      end
      S_LYL: begin
        mul_a = MA_W'(fracy_q);
        mul_b = MB_W'(dly_q[HALF-1:0]);
      end
      S_LYH: begin
        mul_a = MA_W'(fracy_q);
        mul_b = MB_W'(dly_q[QW-1:HALF]);
      end
      default: ;
    endcase
  end

  logic [FULL_W-1:0] len_full;
  logic [LW-1:0]     len_new;
  assign len_full = (FULL_W'(mul_q) << HALF) + FULL_W'(acc_q);
  assign len_new  = LW'(len_full >> FRAC_BITS);

  // square root and divider
  logic              sqrt_start, sqrt_done;
  logic [NORM_W-1:0] sqrt_root;
  assign sqrt_start = (state_q == S_ROOTGO);

  grt_sqrt #(.IN_W(SQ_W)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (SQ_W'(acc_q) + SQ_W'(mul_q)),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  logic          div_start, div_done;
  logic [QW-1:0] div_quot;
  assign div_start = ((state_q == S_DIVXGO) & xon) | ((state_q == S_DIVYGO) & yon);

  grt_div #(.NUM_W(QW), .DEN_W(MAG_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({norm_q, {FRAC_BITS{1'b0}}}),
    .den_i  ((state_q == S_DIVXGO) ? magx_q : magy_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // walk step
  logic                 stop, take_x;
  logic signed [XW-1:0] nx, ny, tx, ty;
  assign stop   = hit_q | oom_q | (dist_q >= LW'(max_dist_q)) | (~xon & ~yon);
  assign take_x = xon & (~yon | (lenx_q < leny_q));
  assign nx     = take_x ? (cx_q + (xneg_q ? STEP_BACK : STEP_FWD)) : cx_q;
  assign ny     = take_x ? cy_q : (cy_q + (yneg_q ? STEP_BACK : STEP_FWD));
  assign tx     = (state_q == S_STEP) ? nx : cx_q;
  assign ty     = (state_q == S_STEP) ? ny : cy_q;

  // map bounds and cell address
  logic [XW-1:0]     tx_u, ty_u;
  logic [PRD_W-1:0]  row_base;
  logic [SUM_W-1:0]  cell_sum;
  logic              probe_ok;
  logic [ADDR_W-1:0] probe_addr;
  assign tx_u       = tx;
  assign ty_u       = ty;
  assign row_base   = PRD_W'(ty_u[CW-1:0]) * PRD_W'(map_width_q);
  assign cell_sum   = SUM_W'(row_base) + SUM_W'(tx_u[CW-1:0]);
  assign probe_ok   = ~tx_u[XW-1] & ~ty_u[XW-1]
                    & (CMP_W'(tx_u) < CMP_W'(map_width_q))
                    & (CMP_W'(tx_u) < CMP_W'(MAP_DIM))
                    & (CMP_W'(ty_u) < CMP_W'(map_height_q))
                    & (CMP_W'(ty_u) < CMP_W'(MAP_DIM))
                    & (cell_sum < SUM_W'(CELLS));
  assign probe_addr = cell_sum[ADDR_W-1:0];

  // wall map
  logic wr_en, wall_rd;
  assign wr_en = in_acc & (opcode_i == OP_WRITE)
               & ((WADDR_W+1)'(cell_index_i) < (WADDR_W+1)'(CELLS));

  grt_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(cell_index_i)),
    .wdata_i (cell_wall_i),
    .raddr_i (probe_addr),
    .rdata_o (wall_rd)
  );

  // sequencer
  logic out_free;
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && opcode_i == OP_CAST) state_d = S_SQX;
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = S_ROOTGO;
      S_ROOTGO: state_d = S_ROOT;
      S_ROOT:   if (sqrt_done) state_d = S_DIVXGO;
      S_DIVXGO: state_d = xon ? S_DIVX : S_DIVYGO;
      S_DIVX:   if (div_done) state_d = S_DIVYGO;
      S_DIVYGO: state_d = yon ? S_DIVY : S_LXL;
      S_DIVY:   if (div_done) state_d = S_LXL;
      S_LXL:    state_d = S_LXH;
      S_LXH:    state_d = S_LYL;
      S_LYL:    state_d = S_LYH;
      S_LYH:    state_d = S_LEND;
      S_LEND:   state_d = S_START;
      S_START:  state_d = S_STEP;
      S_STEP: begin
        if (stop) begin
          state_d = S_OUT;
        end else if (probe_ok) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK:  state_d = S_STEP;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      oom_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        hit_q <= 1'b0;
        oom_q <= 1'b0;
      end else if (state_q == S_START && !probe_ok) begin
        oom_q <= 1'b1;
      end else if (state_q == S_STEP && !stop && !probe_ok) begin
        oom_q <= 1'b1;
      end else if (state_q == S_CHECK) begin
        hit_q <= wall_rd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= MP_W'(mul_a) * MP_W'(mul_b);
    if (state_q == S_SQY || state_q == S_LXH || state_q == S_LYH) begin
      acc_q <= mul_q;
    end
    if (in_acc) begin
      xneg_q  <= rawx[MAG_W-1];
      yneg_q  <= rawy[MAG_W-1];
      magx_q  <= magx_d;
      magy_q  <= magy_d;
      fracx_q <= rawx[MAG_W-1] ? {1'b0, fx} : (ONE - {1'b0, fx});
      fracy_q <= rawy[MAG_W-1] ? {1'b0, fy} : (ONE - {1'b0, fy});
      cx_q    <= XW'(start_x_i >> FRAC_BITS);
      cy_q    <= XW'(start_y_i >> FRAC_BITS);
      dist_q  <= '0;
    end
    if (state_q == S_ROOT && sqrt_done) begin
      norm_q <= sqrt_root;
    end
    if (state_q == S_DIVXGO) begin
      dlx_q <= '0;
    end else if (state_q == S_DIVX && div_done) begin
      dlx_q <= div_quot;
    end
    if (state_q == S_DIVYGO) begin
      dly_q <= '0;
    end else if (state_q == S_DIVY && div_done) begin
      dly_q <= div_quot;
    end
    if (state_q == S_LYL) begin
      lenx_q <= len_new;
    end
    if (state_q == S_LEND) begin
      leny_q <= len_new;
    end
    if (state_q == S_STEP && !stop) begin
      if (take_x) begin
        dist_q <= lenx_q;
        lenx_q <= lenx_q + LW'(dlx_q);
      end else begin
        dist_q <= leny_q;
        leny_q <= leny_q + LW'(dly_q);
      end
      if (probe_ok) begin
        cx_q <= nx;
        cy_q <= ny;
      end
    end
    if (state_q == S_OUT && out_free) begin
      res_dist_q <= (dist_q > LW'(DIST_SAT)) ? DIST_SAT : DIST_W'(dist_q);
      res_hit_q  <= hit_q;
      res_oom_q  <= oom_q;
      res_cx_q   <= cx_q[CELL_W-1:0];
      res_cy_q   <= cy_q[CELL_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distance_o   = res_dist_q;
  assign hit_o        = res_hit_q;
  assign out_of_map_o = res_oom_q;
  assign end_cell_x_o = res_cx_q;
  assign end_cell_y_o = res_cy_q;

endmodule

FILE: sv/grt_checker.sv
`include "grid_ray_traversal_macros.svh"

module grt_checker import grt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              opcode_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DIST_W-1:0] distance_o,
  input logic              hit_o,
  input logic              out_of_map_o
);

  // a pending result holds until its transfer
  `GRT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(distance_o) && $stable(hit_o))

  // a wall stop and a map exit never come together
  `GRT_ASSERT_NOW(a_hit_oom_excl, out_valid_o, !(hit_o && out_of_map_o))

  // a cast keeps the input side closed while it walks
  `GRT_ASSERT_NEXT(a_cast_busy, in_valid_i && in_ready_o && opcode_i == OP_CAST, !in_ready_o)

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (.*);

FILE: tb/tb_grid_ray_traversal.sv
`timescale 1ns / 1ps

module tb_grid_ray_traversal;
  import grt_pkg::*;

  localparam int unsigned NCELLS = 4096;
  localparam longint unsigned FONE = 64'd1 << 16;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              hit;
    logic              out_of_map;
    logic [CELL_W-1:0] end_cell_x;
    logic [CELL_W-1:0] end_cell_y;
  } ray_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DIST_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = 1'b0;
  logic [IDX_W-1:0] cell_index_i = '0;
  logic cell_wall_i = 1'b0;
  logic [POS_W-1:0] start_x_i = '0;
  logic [POS_W-1:0] start_y_i = '0;
  logic signed [DIR_W-1:0] dir_x_i = '0;
  logic signed [DIR_W-1:0] dir_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DIST_W-1:0] distance_o;
  logic hit_o;
  logic out_of_map_o;
  logic [CELL_W-1:0] end_cell_x_o;
  logic [CELL_W-1:0] end_cell_y_o;

  grid_ray_traversal u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the block state
  logic wall_q [NCELLS];
  int unsigned width_q, height_q;
  longint unsigned max_dist_q;

  ray_result_t pending_rays[$];
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit cell_inside(longint cx, longint cy);
    if (cx < 0 || cy < 0) return 1'b0;
    if (cx >= width_q || cx >= 64) return 1'b0;
    if (cy >= height_q || cy >= 64) return 1'b0;
    return (cx + cy * width_q) < NCELLS;
  endfunction

  function automatic ray_result_t trace_ray(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                                            logic [DIR_W-1:0] dx, logic [DIR_W-1:0] dy);
    longint unsigned mx, my, norm, dlx, dly, lenx, leny, trav, fx, fy;
    longint cx, cy, nx, ny, stx, sty;
    bit hit, oom, xon, yon;
    ray_result_t r;
    mx = dx[15] ? (64'd65536 - dx) : dx;
    my = dy[15] ? (64'd65536 - dy) : dy;
    xon = mx != 0;
    yon = my != 0;
    cx = sx >> 16;
    cy = sy >> 16;
    fx = sx[15:0];
    fy = sy[15:0];
    norm = int_sqrt(mx * mx + my * my);
    stx = dx[15] ? -1 : 1;
    sty = dy[15] ? -1 : 1;
    dlx = 0; dly = 0; lenx = 0; leny = 0; trav = 0;
    hit = 0; oom = 0;
    if (xon) begin
      dlx = (norm << 16) / mx;
      lenx = ((dx[15] ? fx : FONE - fx) * dlx) >> 16;
    end
    if (yon) begin
      dly = (norm << 16) / my;
      leny = ((dy[15] ? fy : FONE - fy) * dly) >> 16;
    end
    if (!cell_inside(cx, cy)) begin
      oom = 1;
    end else begin
      while (!hit && !oom && trav < max_dist_q && (xon || yon)) begin
        nx = cx;
        ny = cy;
        if (xon && (!yon || lenx < leny)) begin
          nx = cx + stx;
          trav = lenx;
          lenx += dlx;
        end else begin
          ny = cy + sty;
          trav = leny;
          leny += dly;
        end
        if (!cell_inside(nx, ny)) begin
          oom = 1;
        end else begin
          cx = nx;
          cy = ny;
          if (wall_q[cx + cy * width_q]) hit = 1;
        end
      end
    end
    r.distance = (trav > 64'hFFFFFF) ? DIST_SAT : trav[DIST_W-1:0];
    r.hit = hit;
    r.out_of_map = oom;
    r.end_cell_x = cx[CELL_W-1:0];
    r.end_cell_y = cy[CELL_W-1:0];
    return r;
  endfunction

  // receiver stall
  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= snk_stall_pct);

  // result checker
  always @(posedge clk_i) begin
    ray_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{distance_o, hit_o, out_of_map_o, end_cell_x_o, end_cell_y_o};
      if (pending_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_rays.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("ray mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** grid_ray_traversal: FAILED **");
      $finish;
    end
  end

  task automatic send_item(opcode_e op, int unsigned idx, bit wall,
                           logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                           logic [DIR_W-1:0] dx, logic [DIR_W-1:0] dy);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    cell_index_i <= idx[IDX_W-1:0];
    cell_wall_i <= wall;
    start_x_i <= sx;
    start_y_i <= sy;
    dir_x_i <= dx;
    dir_y_i <= dy;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_WRITE) wall_q[idx] = wall;
    else pending_rays.push_back(trace_ray(sx, sy, dx, dy));
  endtask

  task automatic write_cell(int unsigned idx, bit wall);
    send_item(OP_WRITE, idx, wall, '0, '0, '0, '0);
  endtask

  task automatic cast_ray(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                          logic [DIR_W-1:0] dx, logic [DIR_W-1:0] dy);
    send_item(OP_CAST, 0, 0, sx, sy, dx, dy);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rays.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAP_WIDTH:  width_q = val[DIM_W-1:0];
      CFG_MAP_HEIGHT: height_q = val[DIM_W-1:0];
      CFG_MAX_DIST:   max_dist_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DIR_W-1:0] rand_dir();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return DIR_W'($urandom_range(1, 4));
      default: return DIR_W'($urandom);
    endcase
  endfunction

  task automatic random_ray;
    logic [POS_W-1:0] sx, sy;
    if ($urandom_range(99) < 15) begin
      sx = POS_W'($urandom);
      sy = POS_W'($urandom);
    end else begin
      sx = {6'($urandom_range(width_q - 1)), 16'($urandom)};
      sy = {6'($urandom_range(height_q - 1)), 16'($urandom)};
    end
    cast_ray(sx, sy, rand_dir(), rand_dir());
  endtask

  // every cell gets a defined value before any cast
  task automatic test_map_fill;
    for (int unsigned i = 0; i < NCELLS; i++) write_cell(i, $urandom_range(7) == 0);
  endtask

  task automatic test_directed;
    cast_ray({6'd10, 16'h8000}, {6'd10, 16'h8000}, 16'sd0, 16'sd0);
    cast_ray({6'd5, 16'h8000}, {6'd5, 16'h8000}, 16'sd16384, 16'sd16384);
    cast_ray({6'd0, 16'h0000}, {6'd0, 16'h0000}, 16'sh8000, 16'sd0);
    cast_ray({6'd63, 16'hFFFF}, {6'd63, 16'hFFFF}, 16'sh7FFF, 16'sh7FFF);
    cast_ray({6'd20, 16'h0000}, {6'd30, 16'h1234}, 16'sd0, 16'sh8000);
    cast_ray({6'd20, 16'h4000}, {6'd30, 16'h0000}, 16'sd1, 16'sd0);
    cast_ray({6'd40, 16'hC000}, {6'd2, 16'h0001}, -16'sd1, 16'sd3);
    // hit a known wall straight ahead
    write_cell(12 * 64 + 15, 1'b1);
    write_cell(12 * 64 + 13, 1'b0);
    write_cell(12 * 64 + 14, 1'b0);
    cast_ray({6'd12, 16'h8000}, {6'd12, 16'h8000}, 16'sd16384, 16'sd0);
    // start outside the map, then in its last cell
    write_reg(CFG_MAP_WIDTH, 24'd32);
    write_reg(CFG_MAP_HEIGHT, 24'd20);
    cast_ray({6'd40, 16'h0}, {6'd3, 16'h0}, 16'sd100, 16'sd100);
    cast_ray({6'd3, 16'h0}, {6'd25, 16'h0}, 16'sd100, 16'sd100);
    cast_ray({6'd31, 16'h8000}, {6'd19, 16'h8000}, 16'sd9000, 16'sd7000);
    // zero limit takes no step
    write_reg(CFG_MAX_DIST, 24'd0);
    cast_ray({6'd4, 16'h8000}, {6'd4, 16'h8000}, 16'sd5000, -16'sd5000);
    write_reg(CFG_MAX_DIST, DIST_SAT);
    cast_ray({6'd0, 16'h0}, {6'd0, 16'h0}, 16'sd1, 16'sd2);
    write_reg(CFG_MAP_WIDTH, 24'd64);
    write_reg(CFG_MAP_HEIGHT, 24'd64);
    cast_ray({6'd1, 16'h0}, {6'd62, 16'hFFFF}, 16'sd1, -16'sd1);
  endtask

  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20) write_cell($urandom_range(NCELLS - 1), $urandom_range(5) == 0);
      else random_ray();
    end
  endtask

  initial begin
    for (int i = 0; i < NCELLS; i++) wall_q[i] = 1'b0;
    width_q = MAP_WIDTH_RST;
    height_q = MAP_HEIGHT_RST;
    max_dist_q = MAX_DIST_RST;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_map_fill();
    test_directed();
    test_random(150, 0, 0);
    write_reg(CFG_MAP_WIDTH, 24'd1);
    write_reg(CFG_MAP_HEIGHT, 24'd64);
    write_reg(CFG_MAX_DIST, 24'($urandom_range(24'h3FFFFF)));
    test_random(100, 61, 0);
    write_reg(CFG_MAP_WIDTH, 24'd64);
    write_reg(CFG_MAP_HEIGHT, 24'd1);
    test_random(60, 0, 61);
    write_reg(CFG_MAP_WIDTH, 24'($urandom_range(2, 63)));
    write_reg(CFG_MAP_HEIGHT, 24'($urandom_range(2, 63)));
    write_reg(CFG_MAX_DIST, DIST_SAT);
    test_random(120, 0, 61);
    write_reg(CFG_MAP_WIDTH, 24'd64);
    write_reg(CFG_MAP_HEIGHT, 24'd64);
    write_reg(CFG_MAX_DIST, MAX_DIST_RST);
    test_random(170, 20, 20);
    drain();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** grid_ray_traversal: PASSED **");
    end else begin
      $display("** grid_ray_traversal: FAILED **");
    end
    $finish;
  end

endmodule
